/* src/keyframe_curve_sampler_macros.svh */
// Assertion macros shared by the keyframe curve sampler checkers.
// Depends on nothing; the including module must have aclk and aresetn.
`ifndef KEYFRAME_CURVE_SAMPLER_MACROS_SVH
`define KEYFRAME_CURVE_SAMPLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define KCS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define KCS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* src/kcs_pkg.sv */
// Package of the keyframe curve sampler: item types, codes, FSM states, constants.
// Depends on nothing.
package kcs_pkg;

    localparam int MAX_KEYS_DEF     = 64;
    localparam int COMPONENTS_DEF   = 16;
    localparam int SEARCH_STEPS_DEF = 16;

    localparam int KC_W      = 7;
    localparam int RES_W     = 50;
    localparam int NUM_W     = 48;
    localparam int DEN_W     = 32;
    localparam int LIN_SHIFT = 16;
    localparam int BEZ_SHIFT = 30;

    // Bezier parameter 1.0 in Q1.30.
    localparam logic [30:0] S_ONE = 31'h4000_0000;

    localparam logic signed [RES_W-1:0] RES_MAX = {{(RES_W-32){1'b0}}, 32'h7FFF_FFFF};
    localparam logic signed [RES_W-1:0] RES_MIN = {{(RES_W-32){1'b1}}, 32'h8000_0000};

    localparam logic [1:0] OP_WR_HDR = 2'd0;
    localparam logic [1:0] OP_WR_VAL = 2'd1;
    localparam logic [1:0] OP_SAMPLE = 2'd2;

    localparam logic [1:0] MODE_STEP   = 2'd0;
    localparam logic [1:0] MODE_LINEAR = 2'd1;
    localparam logic [1:0] MODE_BEZIER = 2'd2;

    typedef struct packed {
        logic [1:0]         opcode;
        logic [5:0]         key_index;
        logic [3:0]         component;
        logic signed [31:0] time_value;
        logic [1:0]         mode;
        logic signed [31:0] handle_in_x;
        logic signed [31:0] handle_in_y;
        logic signed [31:0] handle_out_x;
        logic signed [31:0] handle_out_y;
        logic signed [31:0] comp_value;
    } in_item_t;

    typedef struct packed {
        logic signed [31:0] sample_value;
        logic [5:0]         segment_key;
        logic               no_root;
        logic               clipped;
    } out_item_t;

    // One keyframe header as stored in the header memory.
    typedef struct packed {
        logic signed [31:0] time_value;
        logic [1:0]         mode;
        logic signed [31:0] hix;
        logic signed [31:0] hiy;
        logic signed [31:0] hox;
        logic signed [31:0] hoy;
    } hdr_t;

    // Command to the curve evaluator: one lerp (linear) or a full cubic.
    typedef struct packed {
        logic               linear;
        logic signed [31:0] p0;
        logic signed [31:0] p1;
        logic signed [31:0] p2;
        logic signed [31:0] p3;
        logic signed [32:0] s;
    } eval_cmd_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_WALK_RD,
        ST_WALK_CMP,
        ST_RD_K,
        ST_RD_K1,
        ST_RD_K2,
        ST_DISPATCH,
        ST_DIV_WAIT,
        ST_LIN_WAIT,
        ST_BIS_START,
        ST_BIS_WAIT,
        ST_VAL_START,
        ST_VAL_WAIT,
        ST_FINISH
    } state_t;

endpackage

/* src/kcs_key_store.sv */
// Keyframe storage: header memory and component value memory, registered reads.
// Depends on kcs_pkg.
module kcs_key_store import kcs_pkg::*; #(
    parameter int MAX_KEYS   = MAX_KEYS_DEF,
    parameter int COMPONENTS = COMPONENTS_DEF,
    localparam int KEY_AW    = $clog2(MAX_KEYS),
    localparam int VAL_AW    = $clog2(MAX_KEYS * COMPONENTS)
) (
    input  logic               aclk,
    input  logic               hdr_we,
    input  logic [KEY_AW-1:0]  hdr_waddr,
    input  hdr_t               hdr_wdata,
    input  logic [KEY_AW-1:0]  hdr_raddr,
    output hdr_t               hdr_rdata,
    input  logic               val_we,
    input  logic [VAL_AW-1:0]  val_waddr,
    input  logic signed [31:0] val_wdata,
    input  logic [VAL_AW-1:0]  val_raddr,
    output logic signed [31:0] val_rdata
);

    hdr_t               hdr_mem [MAX_KEYS];
    logic signed [31:0] val_mem [MAX_KEYS * COMPONENTS];
    hdr_t               hdr_rdata_reg;
    logic signed [31:0] val_rdata_reg;

    // Header memory: one write port, one registered read port.
    always_ff @(posedge aclk) begin
        if (hdr_we) begin
            hdr_mem[hdr_waddr] <= hdr_wdata;
        end
        hdr_rdata_reg <= hdr_mem[hdr_raddr];
    end

    // Value memory, addressed by key times component count plus component.
    always_ff @(posedge aclk) begin
        if (val_we) begin
            val_mem[val_waddr] <= val_wdata;
        end
        val_rdata_reg <= val_mem[val_raddr];
    end

    assign hdr_rdata = hdr_rdata_reg;
    assign val_rdata = val_rdata_reg;

endmodule

/* src/kcs_divider.sv */
// Restoring divider for the linear segment parameter, one quotient bit per cycle.
// Depends on kcs_pkg.
module kcs_divider import kcs_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quo
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [DEN_W-1:0] rem_reg, rem_next;
    logic [DEN_W-1:0] den_reg, den_next;
    logic [NUM_W-1:0] quo_reg, quo_next;
    logic [DEN_W:0]   shifted;
    logic [DEN_W:0]   diff;

    // Shift in the next dividend bit and subtract when the divisor fits.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        shifted   = {rem_reg, quo_reg[NUM_W-1]};
        diff      = shifted - {1'b0, den_reg};
        if (start) begin
            busy_next = 1'b1;
            cnt_next  = '0;
            rem_next  = '0;
            den_next  = den;
            quo_next  = num;
        end else if (busy_reg) begin
            if (shifted >= {1'b0, den_reg}) begin
                rem_next = diff[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b1};
            end else begin
                rem_next = shifted[DEN_W-1:0];
                quo_next = {quo_reg[NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(NUM_W - 1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign done = done_reg;
    assign quo  = quo_reg;

endmodule

/* src/kcs_curve_eval.sv */
// Curve evaluator: one shared multiplier runs de Casteljau lerps in sequence.
// A linear command is a single lerp with a 16-bit shift. Depends on kcs_pkg.
module kcs_curve_eval import kcs_pkg::*; (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    start,
    input  eval_cmd_t               cmd,
    output logic                    done,
    output logic signed [RES_W-1:0] result
);

    logic                    busy_reg, busy_next;
    logic                    done_reg, done_next;
    logic [2:0]              step_reg, step_next;
    eval_cmd_t               cmd_reg, cmd_next;
    logic signed [65:0]      prod_reg, prod_next;
    logic signed [31:0]      base_reg, base_next;
    logic signed [31:0]      a_reg, a_next, b_reg, b_next, c_reg, c_next;
    logic signed [31:0]      d_reg, d_next, e_reg, e_next;
    logic signed [RES_W-1:0] res_reg, res_next;

    logic                    issue;
    logic signed [31:0]      op_a, op_b;
    logic signed [32:0]      diff;
    logic signed [65:0]      shifted;
    logic signed [65:0]      sum;
    logic signed [RES_W-1:0] lerp_out;

    // Operand selection per step: three first-level lerps, two second, one final.
    always_comb begin
        issue = 1'b1;
        op_a  = cmd_reg.p0;
        op_b  = cmd_reg.p1;
        case (step_reg)
            3'd0: begin
                op_a = cmd_reg.p0;
                op_b = cmd_reg.p1;
            end
            3'd1: begin
                op_a = cmd_reg.p1;
                op_b = cmd_reg.p2;
            end
            3'd2: begin
                op_a = cmd_reg.p2;
                op_b = cmd_reg.p3;
            end
            3'd3: begin
                op_a = a_reg;
                op_b = b_reg;
            end
            3'd4: begin
                op_a = b_reg;
                op_b = c_reg;
            end
            3'd6: begin
                op_a = d_reg;
                op_b = e_reg;
            end
            default: issue = 1'b0;
        endcase
        diff = {op_b[31], op_b} - {op_a[31], op_a};
    end

    // Lerp output from the registered product: base plus floor of the scaled product.
    always_comb begin
        if (cmd_reg.linear) begin
            shifted = prod_reg >>> LIN_SHIFT;
        end else begin
            shifted = prod_reg >>> BEZ_SHIFT;
        end
        sum      = $signed({{34{base_reg[31]}}, base_reg}) + shifted;
        lerp_out = sum[RES_W-1:0];
    end

    // Step sequencer and captures of intermediate points.
    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        step_next = step_reg;
        cmd_next  = cmd_reg;
        prod_next = prod_reg;
        base_next = base_reg;
        a_next    = a_reg;
        b_next    = b_reg;
        c_next    = c_reg;
        d_next    = d_reg;
        e_next    = e_reg;
        res_next  = res_reg;
        if (start) begin
            busy_next = 1'b1;
            step_next = '0;
            cmd_next  = cmd;
        end else if (busy_reg) begin
            if (issue) begin
                prod_next = diff * cmd_reg.s;
                base_next = op_a;
            end
            case (step_reg)
                3'd1: a_next = lerp_out[31:0];
                3'd2: b_next = lerp_out[31:0];
                3'd3: c_next = lerp_out[31:0];
                3'd4: d_next = lerp_out[31:0];
                3'd5: e_next = lerp_out[31:0];
                default: ;
            endcase
            if ((cmd_reg.linear && step_reg == 3'd1) || step_reg == 3'd7) begin
                res_next  = lerp_out;
                done_next = 1'b1;
                busy_next = 1'b0;
            end
            step_next = step_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            step_reg <= step_next;
        end
    end

    always_ff @(posedge aclk) begin
        cmd_reg  <= cmd_next;
        prod_reg <= prod_next;
        base_reg <= base_next;
        a_reg    <= a_next;
        b_reg    <= b_next;
        c_reg    <= c_next;
        d_reg    <= d_next;
        e_reg    <= e_next;
        res_reg  <= res_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule

/* src/keyframe_curve_sampler.sv */
// Keyframe curve sampler top level: FSM around the key store, divider and evaluator.
// Write items are taken from IDLE. A sample walks the keys, reading and comparing each
// successor, then reads keys k and k+1 and picks the segment. Step: straight to output.
// Linear: the 48-bit divider, then one lerp. Bezier: bisection steps (8-step evaluator),
// then the value curve. One item at a time. Synchronous active-low reset clears control
// and sets key_count to 1; the memories are not cleared. Depends on kcs_pkg, submodules.
module keyframe_curve_sampler import kcs_pkg::*; #(
    parameter int MAX_KEYS     = MAX_KEYS_DEF,
    parameter int COMPONENTS   = COMPONENTS_DEF,
    parameter int SEARCH_STEPS = SEARCH_STEPS_DEF
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  in_item_t        s_item,
    output logic            m_valid,
    input  logic            m_ready,
    output out_item_t       m_item,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [KC_W-1:0] cfg_wdata
);

    localparam int KEY_AW = $clog2(MAX_KEYS);
    localparam int VAL_AW = $clog2(MAX_KEYS * COMPONENTS);
    localparam int CNT_W  = $clog2(SEARCH_STEPS);

    state_t                  state_reg, state_next;
    logic [KC_W-1:0]         key_count_reg, key_count_next;
    logic [KEY_AW-1:0]       k_reg, k_next, last_reg, last_next;
    logic signed [31:0]      tv_reg, tv_next;
    logic [3:0]              comp_reg, comp_next;
    logic                    comp_ok_reg, comp_ok_next;
    logic signed [31:0]      t0_reg, t0_next, t1_reg, t1_next;
    logic [1:0]              mode_reg, mode_next;
    logic signed [31:0]      hox_reg, hox_next, hoy_reg, hoy_next;
    logic signed [31:0]      hix_reg, hix_next, hiy_reg, hiy_next;
    logic signed [31:0]      v0_reg, v0_next, v1_reg, v1_next;
    logic                    neg0_reg, neg0_next;
    logic                    qneg_reg, qneg_next;
    logic [30:0]             lo_reg, lo_next, hi_reg, hi_next, mid_reg, mid_next;
    logic [30:0]             s_reg, s_next;
    logic [CNT_W-1:0]        cnt_reg, cnt_next;
    logic                    no_root_reg, no_root_next;
    logic                    clip_reg, clip_next;
    logic signed [RES_W-1:0] res_reg, res_next;
    logic                    m_valid_reg, m_valid_next;
    out_item_t               m_item_reg, m_item_next;

    logic                    hdr_we, val_we;
    logic [KEY_AW-1:0]       hdr_waddr, hdr_raddr;
    logic [VAL_AW-1:0]       val_waddr, val_raddr;
    hdr_t                    hdr_wdata, hdr_rdata;
    logic signed [31:0]      val_rdata;
    logic                    div_start, div_done;
    logic [NUM_W-1:0]        div_num, div_quo;
    logic [DEN_W-1:0]        div_den;
    logic                    eval_start, eval_done;
    eval_cmd_t               eval_cmd;
    logic signed [RES_W-1:0] eval_result;
    logic [KEY_AW-1:0]       k_plus;
    logic [KEY_AW-1:0]       k_pair;

    function automatic logic [VAL_AW-1:0] val_addr(input logic [KEY_AW-1:0] key,
                                                   input logic [3:0] comp);
        val_addr = VAL_AW'(32'(key) * COMPONENTS + 32'(comp));
    endfunction

    assign k_plus = k_reg + 1'b1;
    assign k_pair = (k_reg == last_reg) ? k_reg : k_plus;

    kcs_key_store #(
        .MAX_KEYS   (MAX_KEYS),
        .COMPONENTS (COMPONENTS)
    ) u_store (
        .aclk      (aclk),
        .hdr_we    (hdr_we),
        .hdr_waddr (hdr_waddr),
        .hdr_wdata (hdr_wdata),
        .hdr_raddr (hdr_raddr),
        .hdr_rdata (hdr_rdata),
        .val_we    (val_we),
        .val_waddr (val_waddr),
        .val_wdata (s_item.comp_value),
        .val_raddr (val_raddr),
        .val_rdata (val_rdata)
    );

    kcs_divider u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quo     (div_quo)
    );

    kcs_curve_eval u_eval (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (eval_start),
        .cmd     (eval_cmd),
        .done    (eval_done),
        .result  (eval_result)
    );

    // Write ports follow the input item directly.
    always_comb begin
        hdr_waddr            = KEY_AW'(s_item.key_index);
        val_waddr            = val_addr(KEY_AW'(s_item.key_index), s_item.component);
        hdr_wdata.time_value = s_item.time_value;
        hdr_wdata.mode       = s_item.mode;
        hdr_wdata.hix        = s_item.handle_in_x;
        hdr_wdata.hiy        = s_item.handle_in_y;
        hdr_wdata.hox        = s_item.handle_out_x;
        hdr_wdata.hoy        = s_item.handle_out_y;
    end

    // Read addresses: successor during the walk, then keys k and k+1.
    always_comb begin
        unique case (state_reg)
            ST_WALK_RD: hdr_raddr = k_plus;
            ST_RD_K1:   hdr_raddr = k_pair;
            default:    hdr_raddr = k_reg;
        endcase
        if (!comp_ok_reg) begin
            val_raddr = '0;
        end else if (state_reg == ST_RD_K1) begin
            val_raddr = val_addr(k_pair, comp_reg);
        end else begin
            val_raddr = val_addr(k_reg, comp_reg);
        end
    end

    // Control FSM: next state, datapath register updates and unit starts.
    always_comb begin
        logic signed [32:0] dt;
        logic signed [32:0] dd;
        logic signed [32:0] f0;
        logic signed [32:0] f1;
        logic signed [32:0] fm;
        logic [31:0]        dt_mag;
        logic [31:0]        dd_mag;
        logic [30:0]        mid;
        logic [30:0]        lo_new;
        logic signed [31:0] s_lin;
        logic               s_clip;
        logic               sat_hi;
        logic               sat_lo;

        state_next     = state_reg;
        key_count_next = key_count_reg;
        k_next         = k_reg;
        last_next      = last_reg;
        tv_next        = tv_reg;
        comp_next      = comp_reg;
        comp_ok_next   = comp_ok_reg;
        t0_next        = t0_reg;
        t1_next        = t1_reg;
        mode_next      = mode_reg;
        hox_next       = hox_reg;
        hoy_next       = hoy_reg;
        hix_next       = hix_reg;
        hiy_next       = hiy_reg;
        v0_next        = v0_reg;
        v1_next        = v1_reg;
        neg0_next      = neg0_reg;
        qneg_next      = qneg_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        mid_next       = mid_reg;
        s_next         = s_reg;
        cnt_next       = cnt_reg;
        no_root_next   = no_root_reg;
        clip_next      = clip_reg;
        res_next       = res_reg;
        m_valid_next   = m_valid_reg;
        m_item_next    = m_item_reg;
        hdr_we         = 1'b0;
        val_we         = 1'b0;
        div_start      = 1'b0;
        eval_start     = 1'b0;
        s_ready        = 1'b0;

        dt     = {tv_reg[31], tv_reg} - {t0_reg[31], t0_reg};
        dd     = {t1_reg[31], t1_reg} - {t0_reg[31], t0_reg};
        dt_mag = dt[32] ? 32'(-dt) : dt[31:0];
        dd_mag = dd[32] ? 32'(-dd) : dd[31:0];
        div_num = {dt_mag, 16'h0000};
        div_den = dd_mag;
        f0     = {t0_reg[31], t0_reg} - {tv_reg[31], tv_reg};
        f1     = {t1_reg[31], t1_reg} - {tv_reg[31], tv_reg};
        fm     = {eval_result[31], eval_result[31:0]} - {tv_reg[31], tv_reg};
        mid    = 31'(({1'b0, lo_reg} + {1'b0, hi_reg}) >> 1);
        lo_new = lo_reg;

        // Saturate the divider quotient to the signed 32-bit parameter.
        s_clip = 1'b0;
        if (qneg_reg) begin
            if (div_quo > NUM_W'(33'h0_8000_0000)) begin
                s_lin  = 32'sh8000_0000;
                s_clip = 1'b1;
            end else begin
                s_lin = 32'(-div_quo);
            end
        end else begin
            if (div_quo > NUM_W'(32'h7FFF_FFFF)) begin
                s_lin  = 32'sh7FFF_FFFF;
                s_clip = 1'b1;
            end else begin
                s_lin = div_quo[31:0];
            end
        end

        // Evaluator command: linear lerp, time curve, or value curve.
        eval_cmd.linear = 1'b0;
        eval_cmd.p0     = v0_reg;
        eval_cmd.p1     = hoy_reg;
        eval_cmd.p2     = hiy_reg;
        eval_cmd.p3     = v1_reg;
        eval_cmd.s      = $signed({2'b00, s_reg});
        if (state_reg == ST_DIV_WAIT) begin
            eval_cmd.linear = 1'b1;
            eval_cmd.p1     = v1_reg;
            eval_cmd.s      = $signed({s_lin[31], s_lin});
        end else if (state_reg == ST_BIS_START) begin
            eval_cmd.p0 = t0_reg;
            eval_cmd.p1 = hox_reg;
            eval_cmd.p2 = hix_reg;
            eval_cmd.p3 = t1_reg;
            eval_cmd.s  = $signed({2'b00, mid});
        end

        sat_hi = res_reg > RES_MAX;
        sat_lo = res_reg < RES_MIN;

        // Configuration write.
        if (cfg_valid) begin
            key_count_next = cfg_wdata;
        end

        // Output register drains independently of the FSM.
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    unique case (s_item.opcode)
                        OP_WR_HDR: begin
                            hdr_we = 32'(s_item.key_index) < MAX_KEYS;
                        end
                        OP_WR_VAL: begin
                            val_we = (32'(s_item.key_index) < MAX_KEYS) &&
                                     (32'(s_item.component) < COMPONENTS);
                        end
                        OP_SAMPLE: begin
                            tv_next      = s_item.time_value;
                            comp_next    = s_item.component;
                            comp_ok_next = 32'(s_item.component) < COMPONENTS;
                            k_next       = '0;
                            no_root_next = 1'b0;
                            clip_next    = 1'b0;
                            if (key_count_reg == '0) begin
                                last_next = '0;
                            end else if (32'(key_count_reg) > MAX_KEYS) begin
                                last_next = KEY_AW'(MAX_KEYS - 1);
                            end else begin
                                last_next = KEY_AW'(32'(key_count_reg) - 1);
                            end
                            if (key_count_reg <= KC_W'(1)) begin
                                state_next = ST_RD_K;
                            end else begin
                                state_next = ST_WALK_RD;
                            end
                        end
                        default: ;
                    endcase
                end
            end

            ST_WALK_RD: begin
                state_next = ST_WALK_CMP;
            end

            // Advance while the successor key is not later than the query time.
            ST_WALK_CMP: begin
                if (hdr_rdata.time_value <= tv_reg) begin
                    k_next = k_plus;
                    if (k_plus == last_reg) begin
                        state_next = ST_RD_K;
                    end else begin
                        state_next = ST_WALK_RD;
                    end
                end else begin
                    state_next = ST_RD_K;
                end
            end

            ST_RD_K: begin
                state_next = ST_RD_K1;
            end

            ST_RD_K1: begin
                t0_next    = hdr_rdata.time_value;
                mode_next  = hdr_rdata.mode;
                hox_next   = hdr_rdata.hox;
                hoy_next   = hdr_rdata.hoy;
                v0_next    = comp_ok_reg ? val_rdata : 32'sd0;
                state_next = ST_RD_K2;
            end

            ST_RD_K2: begin
                t1_next    = hdr_rdata.time_value;
                hix_next   = hdr_rdata.hix;
                hiy_next   = hdr_rdata.hiy;
                v1_next    = comp_ok_reg ? val_rdata : 32'sd0;
                state_next = ST_DISPATCH;
            end

            // Pick the interpolation for the segment.
            ST_DISPATCH: begin
                res_next = RES_W'(v0_reg);
                if (k_reg == last_reg || (mode_reg != MODE_LINEAR && mode_reg != MODE_BEZIER)) begin
                    state_next = ST_FINISH;
                end else if (mode_reg == MODE_LINEAR) begin
                    if (dd == '0) begin
                        state_next = ST_FINISH;
                    end else begin
                        qneg_next  = dt[32] ^ dd[32];
                        div_start  = 1'b1;
                        state_next = ST_DIV_WAIT;
                    end
                end else begin
                    neg0_next = f0[32];
                    lo_next   = '0;
                    hi_next   = S_ONE;
                    cnt_next  = '0;
                    if (f0 == '0) begin
                        s_next     = '0;
                        state_next = ST_VAL_START;
                    end else if (f1 == '0) begin
                        s_next     = S_ONE;
                        state_next = ST_VAL_START;
                    end else if (f0[32] == f1[32]) begin
                        no_root_next = 1'b1;
                        s_next       = '0;
                        state_next   = ST_VAL_START;
                    end else begin
                        state_next = ST_BIS_START;
                    end
                end
            end

            ST_DIV_WAIT: begin
                if (div_done) begin
                    clip_next  = s_clip;
                    eval_start = 1'b1;
                    state_next = ST_LIN_WAIT;
                end
            end

            ST_LIN_WAIT: begin
                if (eval_done) begin
                    res_next   = eval_result;
                    state_next = ST_FINISH;
                end
            end

            ST_BIS_START: begin
                mid_next   = mid;
                eval_start = 1'b1;
                state_next = ST_BIS_WAIT;
            end

            // Narrow the bracket by the sign of the time curve at mid.
            ST_BIS_WAIT: begin
                if (eval_done) begin
                    if (fm == '0) begin
                        lo_new  = mid_reg;
                        hi_next = mid_reg;
                    end else if (fm[32] == neg0_reg) begin
                        lo_new = mid_reg;
                    end else begin
                        hi_next = mid_reg;
                    end
                    lo_next  = lo_new;
                    cnt_next = cnt_reg + 1'b1;
                    if (cnt_reg == CNT_W'(SEARCH_STEPS - 1)) begin
                        s_next     = lo_new;
                        state_next = ST_VAL_START;
                    end else begin
                        state_next = ST_BIS_START;
                    end
                end
            end

            ST_VAL_START: begin
                eval_start = 1'b1;
                state_next = ST_VAL_WAIT;
            end

            ST_VAL_WAIT: begin
                if (eval_done) begin
                    res_next   = eval_result;
                    state_next = ST_FINISH;
                end
            end

            // Saturate and hand the item to the output register once it is free.
            ST_FINISH: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next             = 1'b1;
                    m_item_next.segment_key  = 6'(k_reg);
                    m_item_next.no_root      = no_root_reg;
                    m_item_next.clipped      = clip_reg | sat_hi | sat_lo;
                    if (sat_hi) begin
                        m_item_next.sample_value = 32'sh7FFF_FFFF;
                    end else if (sat_lo) begin
                        m_item_next.sample_value = 32'sh8000_0000;
                    end else begin
                        m_item_next.sample_value = res_reg[31:0];
                    end
                    state_next = ST_IDLE;
                end
            end

            default: state_next = ST_IDLE;
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            key_count_reg <= KC_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            key_count_reg <= key_count_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Datapath registers.
    always_ff @(posedge aclk) begin
        k_reg       <= k_next;
        last_reg    <= last_next;
        tv_reg      <= tv_next;
        comp_reg    <= comp_next;
        comp_ok_reg <= comp_ok_next;
        t0_reg      <= t0_next;
        t1_reg      <= t1_next;
        mode_reg    <= mode_next;
        hox_reg     <= hox_next;
        hoy_reg     <= hoy_next;
        hix_reg     <= hix_next;
        hiy_reg     <= hiy_next;
        v0_reg      <= v0_next;
        v1_reg      <= v1_next;
        neg0_reg    <= neg0_next;
        qneg_reg    <= qneg_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        mid_reg     <= mid_next;
        s_reg       <= s_next;
        cnt_reg     <= cnt_next;
        no_root_reg <= no_root_next;
        clip_reg    <= clip_next;
        res_reg     <= res_next;
        m_item_reg  <= m_item_next;
    end

    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_item    = m_item_reg;

endmodule

/* src/kcs_checker.sv */
// Port-level checker for the keyframe curve sampler, bound to the top level.
// Depends on kcs_pkg and keyframe_curve_sampler_macros.svh.
`include "keyframe_curve_sampler_macros.svh"

module kcs_checker import kcs_pkg::*; (
    input logic      aclk,
    input logic      aresetn,
    input logic      s_valid,
    input logic      s_ready,
    input in_item_t  s_item,
    input logic      m_valid,
    input logic      m_ready,
    input out_item_t m_item
);

    // A stalled result item holds.
    `KCS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_item), "result item changed while stalled")

    // Write items never produce a result.
    `KCS_ASSERT_NEXT(a_write_silent, s_valid && s_ready && s_item.opcode != OP_SAMPLE && !m_valid, !m_valid, "write item produced a result")

    // A sample occupies the block, so input is not taken in the next cycle.
    `KCS_ASSERT_NEXT(a_sample_busy, s_valid && s_ready && s_item.opcode == OP_SAMPLE, !s_ready, "input taken while a sample is in work")

    // A bezier result never saturates, so no_root and clipped exclude each other.
    `KCS_ASSERT_NOW(a_noroot_clip, m_valid && m_item.no_root, !m_item.clipped, "no_root and clipped both set")

endmodule

bind keyframe_curve_sampler kcs_checker u_kcs_checker (.*);

/* bench/testbench.sv */
// Self-checking testbench for keyframe_curve_sampler: random and directed items are
// compared against an in-bench predictor of the keyframe table and its sampling.
// Depends on kcs_pkg and the keyframe_curve_sampler RTL.
`timescale 1ns / 1ps

module testbench;
    import kcs_pkg::*;

    localparam logic [1:0] OP_NONE   = 2'd3;
    localparam logic [1:0] MODE_HOLD = 2'd3;
    localparam int         NKEYS     = 64;
    localparam int         NCOMP     = 16;
    localparam int         NSTEPS    = 16;
    localparam int         SETTLE    = 600;
    localparam int         IN_W      = $bits(in_item_t);

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    in_item_t        s_item;
    logic            m_valid;
    logic            m_ready;
    out_item_t       m_item;
    logic            cfg_valid;
    logic            cfg_ready;
    logic [KC_W-1:0] cfg_wdata;

    // Pending items, expected samples and the predicted table.
    in_item_t  item_q[$];
    out_item_t sample_q[$];
    int        key_time[NKEYS];
    logic [1:0] key_mode[NKEYS];
    int        hin_x[NKEYS];
    int        hin_y[NKEYS];
    int        hout_x[NKEYS];
    int        hout_y[NKEYS];
    int        comp_val[NKEYS*NCOMP];
    int        active_keys;
    int        mismatches;
    bit        s_fire;
    bit        calm;
    int        hold_left;

    keyframe_curve_sampler u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_item    (m_item),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_wdata (cfg_wdata)
    );

    // Clock generation.
    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    function automatic longint lerp30(longint a, longint b, longint s);
        return a + (((b - a) * s) >>> BEZ_SHIFT);
    endfunction

    function automatic longint cubic(longint p0, longint p1, longint p2, longint p3,
                                     longint s);
        longint a, b, c, d, e;
        a = lerp30(p0, p1, s);
        b = lerp30(p1, p2, s);
        c = lerp30(p2, p3, s);
        d = lerp30(a, b, s);
        e = lerp30(b, c, s);
        return lerp30(d, e, s);
    endfunction

    // Applies one item to the predicted table; returns 1 when a sample is expected.
    function automatic bit predict_sample(input in_item_t it, output out_item_t r);
        int     n, k, ci;
        longint tv, t0, t1, v0, v1, s, res, f0, f1, lo, hi, mid, fm;
        logic [1:0] md;
        bit     nr, clp, neg0;
        r = '0;
        ci = it.component;
        if (it.opcode == OP_WR_HDR) begin
            key_time[it.key_index] = it.time_value;
            key_mode[it.key_index] = it.mode;
            hin_x[it.key_index]    = it.handle_in_x;
            hin_y[it.key_index]    = it.handle_in_y;
            hout_x[it.key_index]   = it.handle_out_x;
            hout_y[it.key_index]   = it.handle_out_y;
            return 1'b0;
        end
        if (it.opcode == OP_WR_VAL) begin
            comp_val[it.key_index*NCOMP + ci] = it.comp_value;
            return 1'b0;
        end
        if (it.opcode != OP_SAMPLE)
            return 1'b0;
        n = (active_keys == 0) ? 1 : (active_keys > NKEYS) ? NKEYS : active_keys;
        tv = it.time_value;
        k = 0;
        while (k < n - 1 && key_time[k+1] <= tv)
            k++;
        md = key_mode[k];
        nr = 1'b0;
        clp = 1'b0;
        v0 = comp_val[k*NCOMP + ci];
        if (k == n - 1 || (md != MODE_LINEAR && md != MODE_BEZIER)) begin
            res = v0;
        end else begin
            t0 = key_time[k];
            t1 = key_time[k+1];
            v1 = comp_val[(k+1)*NCOMP + ci];
            if (md == MODE_LINEAR) begin
                if (t1 == t0) begin
                    res = v0;
                end else begin
                    s = (tv - t0) * 65536 / (t1 - t0);
                    if (s > 64'sh7FFF_FFFF) begin
                        s = 64'sh7FFF_FFFF;
                        clp = 1'b1;
                    end
                    if (s < -64'sh8000_0000) begin
                        s = -64'sh8000_0000;
                        clp = 1'b1;
                    end
                    res = v0 + (((v1 - v0) * s) >>> LIN_SHIFT);
                end
            end else begin
                // Bezier: find s on the time curve, then evaluate the value curve.
                f0 = t0 - tv;
                f1 = t1 - tv;
                s = 0;
                if (f0 == 0) begin
                    s = 0;
                end else if (f1 == 0) begin
                    s = longint'(1) << BEZ_SHIFT;
                end else if ((f0 < 0) == (f1 < 0)) begin
                    nr = 1'b1;
                end else begin
                    lo = 0;
                    hi = longint'(1) << BEZ_SHIFT;
                    neg0 = f0 < 0;
                    for (int i = 0; i < NSTEPS; i++) begin
                        mid = (lo + hi) >>> 1;
                        fm = cubic(t0, hout_x[k], hin_x[k+1], t1, mid) - tv;
                        if (fm == 0) begin
                            lo = mid;
                            hi = mid;
                        end else if ((fm < 0) == neg0) begin
                            lo = mid;
                        end else begin
                            hi = mid;
                        end
                    end
                    s = lo;
                end
                res = cubic(v0, hout_y[k], hin_y[k+1], v1, s);
            end
        end
        if (res > 64'sh7FFF_FFFF) begin
            res = 64'sh7FFF_FFFF;
            clp = 1'b1;
        end
        if (res < -64'sh8000_0000) begin
            res = -64'sh8000_0000;
            clp = 1'b1;
        end
        r.sample_value = res[31:0];
        r.segment_key  = k[5:0];
        r.no_root      = nr;
        r.clipped      = clp;
        return 1'b1;
    endfunction

    // Monitor: predicts on every accepted item and checks every accepted sample.
    always @(posedge aclk) begin
        out_item_t r, want;
        if (aresetn) begin
            s_fire = s_valid && s_ready;
            if (s_fire && predict_sample(s_item, r))
                sample_q.push_back(r);
            if (cfg_valid && cfg_ready)
                active_keys = cfg_wdata;
            if (m_valid && m_ready) begin
                if (sample_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Unexpected sample %h with none pending", m_item);
                end else begin
                    want = sample_q.pop_front();
                    if (m_item !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Sample mismatch: value %h/%h key %0d/%0d no_root %b/%b clipped %b/%b (expected/actual)",
                                     want.sample_value, m_item.sample_value,
                                     want.segment_key, m_item.segment_key,
                                     want.no_root, m_item.no_root,
                                     want.clipped, m_item.clipped);
                    end
                end
            end
        end
    end

    // Driver: offers the next pending item, with random idle cycles.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (!s_valid || s_fire) begin
            if (item_q.size() > 0 && (calm || $urandom_range(99) >= 22)) begin
                s_item  <= item_q.pop_front();
                s_valid <= 1'b1;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Receiver ready, held low while a hold-off is running.
    always @(negedge aclk) begin
        m_ready <= aresetn && hold_left == 0 && (calm || $urandom_range(99) >= 22);
    end

    // Hold-off counter.
    always @(negedge aclk) begin
        if (hold_left > 0)
            hold_left <= hold_left - 1;
    end

    task automatic put_hdr(int ki, int t, logic [1:0] md, int hix, int hiy, int hox,
                           int hoy);
        in_item_t it;
        it = '0;
        it.opcode = OP_WR_HDR;
        it.key_index = 6'(ki);
        it.time_value = t;
        it.mode = md;
        it.handle_in_x = hix;
        it.handle_in_y = hiy;
        it.handle_out_x = hox;
        it.handle_out_y = hoy;
        it.component = 4'($urandom);
        it.comp_value = $urandom;
        item_q.push_back(it);
    endtask

    task automatic put_val(int ki, int ci, int v);
        in_item_t it;
        it = '0;
        it.opcode = OP_WR_VAL;
        it.key_index = 6'(ki);
        it.component = 4'(ci);
        it.comp_value = v;
        it.time_value = $urandom;
        item_q.push_back(it);
    endtask

    task automatic put_sample(int ci, int t);
        in_item_t it;
        it = '0;
        it.opcode = OP_SAMPLE;
        it.component = 4'(ci);
        it.time_value = t;
        it.key_index = 6'($urandom);
        it.mode = 2'($urandom);
        it.handle_in_x = $urandom;
        it.comp_value = $urandom;
        item_q.push_back(it);
    endtask

    // Waits until all items are in and every expected sample has arrived.
    task automatic drain();
        while (item_q.size() > 0 || s_valid || sample_q.size() > 0)
            @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic set_key_count(int cnt);
        @(negedge aclk);
        cfg_wdata <= KC_W'(cnt);
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    // Loads a sorted curve into the keys in use, then samples it with some noise.
    task automatic run_curve(int cnt, int nitems);
        int     n, seg;
        longint t, step;
        int     span;
        int     times[NKEYS];
        in_item_t junk;
        n = (cnt == 0) ? 1 : (cnt > NKEYS) ? NKEYS : cnt;
        span = ($urandom_range(3) == 0) ? 32'h0100_0000 : 32'h0002_0000;
        t = $signed($urandom) >>> $urandom_range(8, 1);
        for (int i = 0; i < n; i++) begin
            times[i] = int'((t > 64'sh7FFF_FFFF) ? 64'sh7FFF_FFFF : t);
            step = ($urandom_range(9) == 0) ? 0 : $urandom_range(span, 1);
            t = times[i] + step;
        end
        for (int i = 0; i < n; i++) begin
            longint a, b;
            a = (i > 0) ? times[i-1] : times[i];
            b = (i < n - 1) ? times[i+1] : times[i];
            put_hdr(i, times[i], 2'($urandom_range(3)),
                    int'(a + (b - a) * $urandom_range(100) / 100), $urandom,
                    int'(times[i] + (b - times[i]) * $urandom_range(100) / 100),
                    $signed($urandom) >>> $urandom_range(4));
        end
        for (int i = 0; i < nitems; i++) begin
            case ($urandom_range(19))
                0: put_hdr($urandom_range(NKEYS - 1), $urandom, 2'($urandom), $urandom,
                           $urandom, $urandom, $urandom);
                1: put_val($urandom_range(NKEYS - 1), $urandom_range(NCOMP - 1),
                           ($urandom_range(1)) ? $urandom : $signed($urandom) >>> 12);
                2: begin
                    junk = IN_W'({$urandom, $urandom, $urandom, $urandom, $urandom,
                                  $urandom, $urandom, $urandom});
                    junk.opcode = OP_NONE;
                    item_q.push_back(junk);
                end
                3: put_sample($urandom_range(NCOMP - 1), $urandom);
                default: begin
                    seg = $urandom_range(n - 1);
                    put_sample($urandom_range(NCOMP - 1),
                               times[seg] + $signed($urandom_range(span * 5 / 4)) -
                               ((seg == 0) ? span / 8 : 0));
                end
            endcase
        end
        drain();
    endtask

    // Stimulus sequence.
    initial begin
        int counts[10] = '{64, 1, 0, 127, 2, 3, 8, 17, 33, 64};
        aresetn = 1'b0;
        s_valid = 1'b0;
        s_item = '0;
        m_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_wdata = '0;
        active_keys = 1;
        mismatches = 0;
        s_fire = 1'b0;
        calm = 1'b0;
        hold_left = 0;
        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Fill every header and value so that no sample reads an unwritten entry.
        set_key_count(NKEYS);
        for (int i = 0; i < NKEYS; i++)
            put_hdr(i, (i - 8) << 16, MODE_LINEAR, 0, 0, 0, 0);
        for (int i = 0; i < NKEYS * NCOMP; i++)
            put_val(i / NCOMP, i % NCOMP, $urandom);
        put_sample(0, 32'h8000_0000);
        put_sample(NCOMP - 1, 32'h7FFF_FFFF);
        put_sample(3, 5 << 16);
        drain();

        // Two keys: extrapolation clipping, equal times, bezier edges, hold mode.
        set_key_count(2);
        put_hdr(0, 0, MODE_LINEAR, 0, 0, 0, 0);
        put_hdr(1, 32'h0001_0000, MODE_LINEAR, 0, 0, 0, 0);
        put_val(0, 0, 32'h8000_0000);
        put_val(1, 0, 32'h7FFF_FFFF);
        put_sample(0, 32'h8000_0001);
        put_sample(0, 32'h0000_8000);
        put_sample(0, 32'h7FFF_FFFF);
        put_hdr(1, 0, MODE_STEP, 0, 0, 0, 0);
        put_sample(0, -5);
        put_hdr(0, 0, MODE_BEZIER, 0, 0, 32'h0000_4000, 32'h4000_0000);
        put_hdr(1, 32'h0001_0000, MODE_STEP, 32'h0000_C000, 32'hC000_0000, 0, 0);
        put_sample(0, -32'sh100);
        put_sample(0, 0);
        put_sample(0, 32'h0001_0000);
        put_sample(0, 32'h0000_8000);
        put_hdr(0, 0, MODE_HOLD, 0, 0, 0, 0);
        put_sample(0, 32'h0000_8000);
        put_sample(0, 32'h8000_0000);
        begin
            in_item_t junk;
            junk = '1;
            junk.opcode = OP_NONE;
            item_q.push_back(junk);
        end
        drain();

        // Random phases over several key counts.
        for (int p = 0; p < 10; p++) begin
            set_key_count(counts[p]);
            calm = (p == 3);
            if (p == 5)
                hold_left = 400;
            run_curve(counts[p], 60);
        end
        calm = 1'b0;
        set_key_count($urandom_range(64, 1));
        run_curve(active_keys, 60);

        if (mismatches == 0 && sample_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

    // Run limit.
    initial begin
        #50_000_000;
        $display("FAIL");
        $finish;
    end

endmodule
